/* rtl/clsw_pkg.sv */
package clsw_pkg;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 5;
  localparam int FIDX_W   = 4;
  localparam int ECOUNT_W = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND    = 3'd0,
    KIND_SEARCH    = 3'd1,
    KIND_TRUNCATE  = 3'd2,
    KIND_REMOVE_AT = 3'd3,
    KIND_REMOVE_EQ = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } state_t;

  typedef enum logic [1:0] {
    WALK_APPEND,
    WALK_SEARCH,
    WALK_DROP_VAL,
    WALK_DROP_IDX
  } walk_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   position;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [FIDX_W-1:0]   found_index;
    logic [ECOUNT_W-1:0] entry_count;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic       start;
    walk_mode_t mode;
  } walk_cmd_t;

  typedef struct packed {
    logic done;
    logic hit;
  } walk_stat_t;

endpackage

/* rtl/compacting_list_with_search_core.sv */
// Ordered list of up to DEPTH words with append, search, truncate, remove at index and
// remove all equal. One item is worked at a time: in_stall is high from acceptance until
// its result has moved into the output register, and the next item can be accepted in the
// cycle after that. Truncate, rejected requests and unused kinds go from acceptance
// straight to the wait state, append through the run state first. Search, remove at index
// and remove all equal walk the stored entries through the memory, one entry per cycle,
// and a search stops at its first hit. The output register lets the next item be accepted
// while a result still waits on out_stall; a finished item then holds until that register
// frees up, keeping in_stall high.
module compacting_list_with_search_core import clsw_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  out_item_t     res_r, res_nxt;
  out_item_t     out_r;
  logic          out_valid_r, out_valid_nxt;

  logic          in_acc;
  logic          out_free;
  kind_t         kind;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic          full;

  walk_cmd_t     wcmd;
  logic [AW-1:0] wcmd_idx;
  walk_stat_t    wstat;
  logic [AW-1:0] whit_idx;
  logic [CW-1:0] wcnt;

  clsw_walk #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (wcmd),
    .cmd_val (DATA_WIDTH'(in_item.value)),
    .cmd_cnt (count_r),
    .cmd_idx (wcmd_idx),
    .stat    (wstat),
    .hit_idx (whit_idx),
    .new_cnt (wcnt)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign kind     = kind_t'(in_item.kind);
  assign pos_x    = XW'(in_item.position);
  assign cnt_x    = XW'(count_r);
  assign full     = (count_r >= CW'(DEPTH));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (kind)
            KIND_APPEND:    state_nxt = full ? S_WAIT : S_RUN;
            KIND_SEARCH:    state_nxt = S_RUN;
            KIND_REMOVE_EQ: state_nxt = S_RUN;
            KIND_REMOVE_AT: state_nxt = (pos_x < cnt_x) ? S_RUN : S_WAIT;
            default:        state_nxt = S_WAIT;
          endcase
        end
      end
      S_RUN: begin
        if (wstat.done) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    wcmd.start    = 1'b0;
    wcmd.mode     = WALK_SEARCH;
    wcmd_idx      = AW'(in_item.position);
    count_nxt     = count_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_nxt.found       = 1'b0;
          res_nxt.found_index = '0;
          res_nxt.entry_count = ECOUNT_W'(count_r);
          res_nxt.status      = STATUS_OK;
          unique case (kind)
            KIND_APPEND: begin
              if (full) begin
                res_nxt.status = STATUS_FULL;
              end else begin
                wcmd.start = 1'b1;
                wcmd.mode  = WALK_APPEND;
              end
            end
            KIND_SEARCH: begin
              wcmd.start = 1'b1;
              wcmd.mode  = WALK_SEARCH;
            end
            KIND_TRUNCATE: begin
              if (pos_x > cnt_x) begin
                res_nxt.status = STATUS_RANGE;
              end else begin
                count_nxt           = CW'(in_item.position);
                res_nxt.entry_count = ECOUNT_W'(in_item.position);
              end
            end
            KIND_REMOVE_AT: begin
              if (pos_x < cnt_x) begin
                wcmd.start = 1'b1;
                wcmd.mode  = WALK_DROP_IDX;
              end else begin
                res_nxt.status = STATUS_RANGE;
              end
            end
            KIND_REMOVE_EQ: begin
              wcmd.start = 1'b1;
              wcmd.mode  = WALK_DROP_VAL;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (wstat.done) begin
          count_nxt           = wcnt;
          res_nxt.found       = wstat.hit;
          res_nxt.found_index = wstat.hit ? FIDX_W'(whit_idx) : '0;
          res_nxt.entry_count = ECOUNT_W'(wcnt);
        end
      end
      S_WAIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    res_r <= res_nxt;
    if ((state_r == S_WAIT) && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above capacity");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted item left no work");

  a_out_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WAIT))
    else $error("result shown without a finished item");

endmodule

/* rtl/clsw_ram.sv */
module clsw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/clsw_walk.sv */
module clsw_walk import clsw_pkg::*; #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  walk_cmd_t                  cmd,
  input  logic [DATA_WIDTH-1:0]      cmd_val,
  input  logic [$clog2(DEPTH+1)-1:0] cmd_cnt,
  input  logic [$clog2(DEPTH)-1:0]   cmd_idx,
  output walk_stat_t                 stat,
  output logic [$clog2(DEPTH)-1:0]   hit_idx,
  output logic [$clog2(DEPTH+1)-1:0] new_cnt
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                  busy_r, busy_nxt;
  walk_mode_t            mode_r, mode_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         rd_r, rd_nxt;
  logic [CW-1:0]         wr_r, wr_nxt;
  logic                  dv_r, dv_nxt;
  logic [AW-1:0]         di_r, di_nxt;

  logic                  issue;
  logic                  match;
  logic                  keep;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [DATA_WIDTH-1:0] rdata;

  clsw_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_r[AW-1:0]),
    .rdata (rdata)
  );

  assign issue = busy_r && (mode_r != WALK_APPEND) && (rd_r < cnt_r);
  // shared compare against the stored word just read
  assign match = (rdata == val_r);

  always_comb begin
    we        = 1'b0;
    waddr     = wr_r[AW-1:0];
    wdata     = rdata;
    keep      = 1'b0;
    stat.done = 1'b0;
    stat.hit  = 1'b0;
    hit_idx   = di_r;
    new_cnt   = cnt_r;
    if (busy_r) begin
      unique case (mode_r)
        WALK_APPEND: begin
          we        = 1'b1;
          waddr     = cnt_r[AW-1:0];
          wdata     = val_r;
          stat.done = 1'b1;
          new_cnt   = CW'(cnt_r + 1'b1);
        end
        WALK_SEARCH: begin
          if (dv_r && match) begin
            stat.done = 1'b1;
            stat.hit  = 1'b1;
          end else if (!issue && !dv_r) begin
            stat.done = 1'b1;
          end
        end
        WALK_DROP_VAL, WALK_DROP_IDX: begin
          keep      = (mode_r == WALK_DROP_IDX) ? (di_r != idx_r) : !match;
          we        = dv_r && keep;
          stat.done = !issue && !dv_r;
          new_cnt   = wr_r;
        end
        default: begin
          stat.done = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    mode_nxt = mode_r;
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    rd_nxt   = rd_r;
    wr_nxt   = wr_r;
    dv_nxt   = dv_r;
    di_nxt   = di_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      mode_nxt = cmd.mode;
      val_nxt  = cmd_val;
      cnt_nxt  = cmd_cnt;
      idx_nxt  = cmd_idx;
      rd_nxt   = (cmd.mode == WALK_DROP_IDX) ? CW'(cmd_idx) : '0;
      wr_nxt   = (cmd.mode == WALK_DROP_IDX) ? CW'(cmd_idx) : '0;
      dv_nxt   = 1'b0;
    end else begin
      busy_nxt = busy_r && !stat.done;
      rd_nxt   = issue ? CW'(rd_r + 1'b1) : rd_r;
      wr_nxt   = (we && (mode_r != WALK_APPEND)) ? CW'(wr_r + 1'b1) : wr_r;
      dv_nxt   = issue && !stat.done;
      di_nxt   = rd_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dv_r   <= 1'b0;
      rd_r   <= '0;
      wr_r   <= '0;
    end else begin
      busy_r <= busy_nxt;
      dv_r   <= dv_nxt;
      rd_r   <= rd_nxt;
      wr_r   <= wr_nxt;
    end
    mode_r <= mode_nxt;
    val_r  <= val_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    di_r   <= di_nxt;
  end

  // compaction never writes ahead of the read pointer
  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && (mode_r != WALK_APPEND) |-> wr_r <= rd_r)
    else $error("write pointer passed read pointer");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> !busy_r)
    else $error("walk still busy after done");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r)
    else $error("walk started while busy");

endmodule

/* bench/tb_top.sv */
module tb_top import clsw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int DATA_WIDTH = 32;
  localparam int MAX_GAP = 14;
  localparam int RANDOM_ITEMS = 1950;
  localparam int IDLE_LIMIT = 1000;
  localparam int TAIL_CYCLES = 40;
  localparam int KIND_FIRST_UNUSED = 5;
  localparam int KIND_UNUSED_COUNT = 3;
  localparam int REPORT_LIMIT = 10;

  class list_scoreboard;
    logic [DATA_WIDTH-1:0] words [DEPTH];
    int held;
    out_item_t expected_q [$];
    int failures;
    int reported;

    function new();
      held = 0;
      failures = 0;
      reported = 0;
    endfunction

    function void note_request(in_item_t req);
      out_item_t exp;
      int kept;
      exp = '0;
      case (req.kind)
        KIND_APPEND: begin
          if (held < DEPTH) begin
            words[held] = req.value;
            held++;
          end else begin
            exp.status = STATUS_FULL;
          end
        end
        KIND_SEARCH: begin
          for (int i = 0; i < held; i++) begin
            if (!exp.found && words[i] == req.value) begin
              exp.found = 1'b1;
              exp.found_index = FIDX_W'(i);
            end
          end
        end
        KIND_TRUNCATE: begin
          if (req.position > held) exp.status = STATUS_RANGE;
          else held = req.position;
        end
        KIND_REMOVE_AT: begin
          if (req.position >= held) begin
            exp.status = STATUS_RANGE;
          end else begin
            for (int i = req.position; i < held - 1; i++) words[i] = words[i + 1];
            held--;
          end
        end
        KIND_REMOVE_EQ: begin
          kept = 0;
          for (int i = 0; i < held; i++) begin
            if (words[i] != req.value) begin
              words[kept] = words[i];
              kept++;
            end
          end
          held = kept;
        end
        default: ;
      endcase
      exp.entry_count = ECOUNT_W'(held);
      expected_q.push_back(exp);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (expected_q.size() == 0) begin
        failures++;
        reported++;
        if (reported <= REPORT_LIMIT)
          $display("result with no request pending: found=%0d idx=%0d count=%0d status=%0d",
                   got.found, got.found_index, got.entry_count, got.status);
        return;
      end
      exp = expected_q.pop_front();
      if (got.found !== exp.found || got.found_index !== exp.found_index ||
          got.entry_count !== exp.entry_count || got.status !== exp.status) begin
        failures++;
        reported++;
        if (reported <= REPORT_LIMIT) begin
          $display("mismatch at %0t: expected found=%0d idx=%0d count=%0d status=%0d",
                   $realtime, exp.found, exp.found_index, exp.entry_count, exp.status);
          $display("  got found=%0d idx=%0d count=%0d status=%0d",
                   got.found, got.found_index, got.entry_count, got.status);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  list_scoreboard sb = new();
  bit no_idle = 1'b0;
  logic [DATA_WIDTH-1:0] value_pool [8];

  compacting_list_with_search_core #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always #6 clk = ~clk;

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic in_item_t make_req(logic [KIND_W-1:0] kind, logic [VALUE_W-1:0] value,
                                        logic [POS_W-1:0] position);
    in_item_t r;
    r.kind = kind;
    r.value = value;
    r.position = position;
    return r;
  endfunction

  function automatic in_item_t random_request();
    in_item_t r;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50 && sb.held > 0) r.value = sb.words[$urandom_range(0, sb.held - 1)];
    else if (roll < 80) r.value = value_pool[$urandom_range(0, 7)];
    else r.value = $urandom();
    if ($urandom_range(0, 9) < 7) r.position = POS_W'($urandom_range(0, sb.held));
    else r.position = POS_W'($urandom_range(0, 31));
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      r.kind = KIND_W'(KIND_FIRST_UNUSED + $urandom_range(0, KIND_UNUSED_COUNT - 1));
    end else if (roll < 40) begin
      r.kind = KIND_APPEND;
    end else if (roll < 65) begin
      r.kind = KIND_SEARCH;
    end else if (roll < 72) begin
      r.kind = KIND_TRUNCATE;
      if ($urandom_range(0, 3) != 0) r.position = POS_W'($urandom_range(sb.held / 2, sb.held));
    end else if (roll < 86) begin
      r.kind = KIND_REMOVE_AT;
    end else begin
      r.kind = KIND_REMOVE_EQ;
    end
    return r;
  endfunction

  task automatic send_request(input in_item_t req);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_request(req);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // result side
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_result(out_item);
        stall_left = draw_gap();
        out_stall <= (stall_left > 0);
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= (stall_left > 0);
      end
    end
  end

  // watchdog on cycles without any item moving
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (int i = 2; i < 8; i++) value_pool[i] = $urandom();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list
    send_request(make_req(KIND_SEARCH, 32'h0000_0001, '0));
    send_request(make_req(KIND_REMOVE_AT, '0, '0));
    send_request(make_req(KIND_TRUNCATE, '0, '0));
    send_request(make_req(KIND_TRUNCATE, '0, 5'd1));
    send_request(make_req(KIND_REMOVE_EQ, '0, '0));
    for (int k = 0; k < KIND_UNUSED_COUNT; k++)
      send_request(make_req(KIND_W'(KIND_FIRST_UNUSED + k), $urandom(), POS_W'($urandom())));

    // fill up, then overflow
    send_request(make_req(KIND_APPEND, 32'h0000_0000, '0));
    send_request(make_req(KIND_APPEND, 32'hFFFF_FFFF, 5'd31));
    send_request(make_req(KIND_APPEND, 32'h5555_5555, '0));
    send_request(make_req(KIND_APPEND, 32'hAAAA_AAAA, '0));
    send_request(make_req(KIND_APPEND, 32'h0000_0000, '0));
    for (int i = 5; i < DEPTH; i++) send_request(make_req(KIND_APPEND, $urandom(), '0));
    send_request(make_req(KIND_APPEND, 32'h1234_5678, '0));

    send_request(make_req(KIND_SEARCH, 32'hAAAA_AAAA, '0));
    send_request(make_req(KIND_SEARCH, 32'h0000_0000, '0));
    send_request(make_req(KIND_REMOVE_AT, '0, 5'd16));
    send_request(make_req(KIND_REMOVE_AT, '0, 5'd31));
    send_request(make_req(KIND_REMOVE_AT, '0, 5'd15));
    send_request(make_req(KIND_TRUNCATE, '0, 5'd31));
    send_request(make_req(KIND_TRUNCATE, '0, 5'd16));
    send_request(make_req(KIND_TRUNCATE, '0, 5'd15));
    send_request(make_req(KIND_REMOVE_EQ, 32'h0000_0000, '0));
    send_request(make_req(KIND_REMOVE_EQ, 32'h0000_0000, '0));
    send_request(make_req(KIND_REMOVE_AT, '0, '0));
    send_request(make_req(KIND_TRUNCATE, '0, '0));
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n % 400 == 200) drain_results();
      send_request(random_request());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/clsw_pkg.sv
rtl/clsw_ram.sv
rtl/clsw_walk.sv
rtl/compacting_list_with_search_core.sv
bench/tb_top.sv
